// ===== hdl/sfrc_pkg.sv =====
package sfrc_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    localparam logic [7:0] SYX_START = 8'hF0;
    localparam logic [7:0] SYX_END   = 8'hF7;

    localparam int CFG_NUM   = 4;
    localparam int HDR_LEN   = 4;
    localparam int MIN_FILL  = 7;
    localparam int MAX_EMIT  = 59;
    localparam int EMIT_SKIP = 6;

    localparam logic [1:0] CFG_MAKER_ID  = 2'd0;
    localparam logic [1:0] CFG_PRODUCT_HI = 2'd1;
    localparam logic [1:0] CFG_PRODUCT_LO = 2'd2;
    localparam logic [1:0] CFG_VERSION   = 2'd3;

    localparam logic [6:0] RST_MAKER_ID   = 7'h7D;
    localparam logic [6:0] RST_PRODUCT_HI = 7'h50;
    localparam logic [6:0] RST_PRODUCT_LO = 7'h53;
    localparam logic [6:0] RST_VERSION    = 7'h01;

endpackage

// ===== hdl/sysex_frame_receiver_checker_core.sv =====
// SysEx frame receiver. A word is taken when i_start is high and o_busy is
// low. Bytes inside a frame are written to the capture memory in the cycle
// they are taken, so data words, starts and aborts never raise o_busy. An end
// word (F7) raises o_busy while a sequencer reads the four header entries back
// from the memory and, if the frame passes, reads one entry per cycle to emit
// command, request and payload bytes, all through the single memory read port.
// Each emitted byte shows on the output ports for one cycle with o_strobe; the
// receiver cannot stall it, and the last one may show in the first cycle after
// o_busy falls.
module sysex_frame_receiver_checker_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_rx_byte,
    output logic       o_busy,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    output logic       o_strobe,
    output logic [6:0] o_frame_byte,
    output logic [5:0] o_byte_position,
    output logic       o_final_byte
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int XW = AW + 7;

    logic [6:0] r_mem [BUFFER_DEPTH];
    logic [6:0] r_rd_data;

    sfrc_pkg::t_state r_state, n_state;

    logic [6:0]    r_cfg [sfrc_pkg::CFG_NUM];
    logic          r_in_frame;
    logic [FW-1:0] r_fill;
    logic [6:0]    r_sum;
    logic [1:0]    r_idx;
    logic          r_hdr_ok;
    logic [5:0]    r_k;
    logic [5:0]    r_last;
    logic          r_strobe;
    logic [5:0]    r_pos;
    logic          r_fin;

    logic          w_accept;
    logic          w_is_start;
    logic          w_is_end;
    logic          w_is_data;
    logic          w_full;
    logic          w_wr_en;
    logic          w_abort;
    logic [AW-1:0] w_rd_addr;
    logic          w_issue;
    logic          w_hdr_eq;
    logic          w_ok;
    logic [XW-1:0] w_emit_addr;
    logic [XW-1:0] w_span;
    logic [5:0]    w_last;
    logic [1:0]    w_cmp_idx;

    assign w_accept   = i_start && !o_busy;
    assign w_is_start = w_accept && (i_rx_byte == sfrc_pkg::SYX_START);
    assign w_is_end   = w_accept && r_in_frame && (i_rx_byte == sfrc_pkg::SYX_END);
    assign w_is_data  = w_accept && r_in_frame && !i_rx_byte[7];
    assign w_full     = (r_fill == FW'(BUFFER_DEPTH));
    assign w_wr_en    = w_is_data && !w_full;
    assign w_abort    = w_accept && r_in_frame && !w_is_start && !w_is_end
                        && (i_rx_byte[7] || w_full);

    assign w_emit_addr = XW'(r_k) + XW'(sfrc_pkg::HDR_LEN);
    assign w_span      = XW'(r_fill) - XW'(sfrc_pkg::EMIT_SKIP);
    assign w_last      = (w_span > XW'(sfrc_pkg::MAX_EMIT - 1)) ?
                         6'(sfrc_pkg::MAX_EMIT - 1) : w_span[5:0];

    assign w_cmp_idx = (r_state == sfrc_pkg::ST_DECIDE) ? sfrc_pkg::CFG_VERSION
                                                         : r_idx - 2'd1;
    assign w_hdr_eq  = (r_rd_data == r_cfg[w_cmp_idx]);
    assign w_ok      = r_hdr_ok && w_hdr_eq && (r_sum == 7'd0)
                       && (r_fill >= FW'(sfrc_pkg::MIN_FILL));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_fill[AW-1:0]] <= i_rx_byte[6:0];
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sfrc_pkg::ST_IDLE: begin
                if (w_is_end) begin
                    n_state = sfrc_pkg::ST_HDR;
                end
            end
            sfrc_pkg::ST_HDR: begin
                if (r_idx == sfrc_pkg::CFG_VERSION) begin
                    n_state = sfrc_pkg::ST_DECIDE;
                end
            end
            sfrc_pkg::ST_DECIDE: begin
                n_state = w_ok ? sfrc_pkg::ST_EMIT : sfrc_pkg::ST_IDLE;
            end
            sfrc_pkg::ST_EMIT: begin
                if (r_k == r_last) begin
                    n_state = sfrc_pkg::ST_IDLE;
                end
            end
            default: n_state = sfrc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy    = 1'b1;
        w_issue   = 1'b0;
        w_rd_addr = w_emit_addr[AW-1:0];
        case (r_state)
            sfrc_pkg::ST_IDLE: begin
                o_busy = 1'b0;
            end
            sfrc_pkg::ST_HDR: begin
                w_rd_addr = AW'(r_idx);
            end
            sfrc_pkg::ST_DECIDE: begin
            end
            sfrc_pkg::ST_EMIT: begin
                w_issue = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sfrc_pkg::ST_IDLE;
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            r_strobe   <= 1'b0;
            r_cfg[sfrc_pkg::CFG_MAKER_ID]   <= sfrc_pkg::RST_MAKER_ID;
            r_cfg[sfrc_pkg::CFG_PRODUCT_HI] <= sfrc_pkg::RST_PRODUCT_HI;
            r_cfg[sfrc_pkg::CFG_PRODUCT_LO] <= sfrc_pkg::RST_PRODUCT_LO;
            r_cfg[sfrc_pkg::CFG_VERSION]    <= sfrc_pkg::RST_VERSION;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_issue;
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            if (w_is_start) begin
                r_in_frame <= 1'b1;
                r_fill     <= '0;
            end else if (w_is_end) begin
                r_in_frame <= 1'b0;
            end else if (w_abort) begin
                r_in_frame <= 1'b0;
                r_fill     <= '0;
            end else if (w_wr_en) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_is_start) begin
            r_sum <= 7'd0;
        end else if (w_wr_en) begin
            r_sum <= r_sum + i_rx_byte[6:0];
        end
        if (w_is_end) begin
            r_idx    <= 2'd0;
            r_hdr_ok <= 1'b1;
        end else if (r_state == sfrc_pkg::ST_HDR) begin
            r_idx <= r_idx + 2'd1;
            if (r_idx != 2'd0) begin
                r_hdr_ok <= r_hdr_ok && w_hdr_eq;
            end
        end
        if (r_state == sfrc_pkg::ST_DECIDE) begin
            r_k    <= 6'd0;
            r_last <= w_last;
        end else if (w_issue) begin
            r_k <= r_k + 6'd1;
        end
        r_pos <= r_k;
        r_fin <= (r_k == r_last);
    end

    assign o_strobe        = r_strobe;
    assign o_frame_byte    = r_rd_data;
    assign o_byte_position = r_pos;
    assign o_final_byte    = r_fin;

    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == sfrc_pkg::ST_EMIT))
        else $error("strobe without emit read");

    a_position_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_final_byte) |=>
            (o_strobe && (o_byte_position == 6'($past(o_byte_position) + 6'd1))))
        else $error("emitted bytes not consecutive");

    a_no_frame_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !r_in_frame)
        else $error("emission while capturing");

endmodule

// ===== sim/sfrc_frame_checker.sv =====
`timescale 1ns / 100ps

module sfrc_frame_checker #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [7:0] i_rx_byte,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data,
    input  logic       i_strobe,
    input  logic [6:0] i_frame_byte,
    input  logic [5:0] i_byte_position,
    input  logic       i_final_byte,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [6:0] data;
        logic [5:0] pos;
        logic       last;
    } t_frame_word;

    t_frame_word frame_words_due [$];
    logic [6:0]  capture_mem [BUFFER_DEPTH];
    logic [6:0]  header_cfg [sfrc_pkg::CFG_NUM];
    int          capture_fill;
    bit          receiving;
    int          fails;

    function automatic bit frame_passes();
        int sum;
        sum = 0;
        if (capture_fill < sfrc_pkg::MIN_FILL || capture_fill > BUFFER_DEPTH) return 1'b0;
        for (int i = 0; i < sfrc_pkg::HDR_LEN; i++) begin
            if (capture_mem[i] != header_cfg[i]) return 1'b0;
        end
        for (int i = 0; i < capture_fill; i++) sum = (sum + capture_mem[i]) & 'h7f;
        return sum == 0;
    endfunction

    task automatic absorb_rx_byte(input logic [7:0] b);
        t_frame_word w;
        int n;
        if (b == sfrc_pkg::SYX_START) begin
            capture_fill = 0;
            receiving = 1'b1;
        end else if (receiving) begin
            if (b == sfrc_pkg::SYX_END) begin
                receiving = 1'b0;
                if (frame_passes()) begin
                    n = capture_fill - (sfrc_pkg::HDR_LEN + 1);
                    if (n > sfrc_pkg::MAX_EMIT) n = sfrc_pkg::MAX_EMIT;
                    for (int k = 0; k < n; k++) begin
                        w.data = capture_mem[sfrc_pkg::HDR_LEN + k];
                        w.pos  = 6'(k);
                        w.last = (k == n - 1);
                        frame_words_due.push_back(w);
                    end
                end
            end else if (b[7] || capture_fill >= BUFFER_DEPTH) begin
                receiving = 1'b0;
                capture_fill = 0;
            end else begin
                capture_mem[capture_fill] = b[6:0];
                capture_fill++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_word want;
        if (!i_rst_n) begin
            frame_words_due.delete();
            capture_fill = 0;
            receiving = 1'b0;
            header_cfg[sfrc_pkg::CFG_MAKER_ID]   = sfrc_pkg::RST_MAKER_ID;
            header_cfg[sfrc_pkg::CFG_PRODUCT_HI] = sfrc_pkg::RST_PRODUCT_HI;
            header_cfg[sfrc_pkg::CFG_PRODUCT_LO] = sfrc_pkg::RST_PRODUCT_LO;
            header_cfg[sfrc_pkg::CFG_VERSION]    = sfrc_pkg::RST_VERSION;
        end else begin
            // compare before predicting: a word on the ports belongs to an older frame
            if (i_strobe) begin
                if (frame_words_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word, exp none, got byte=%h pos=%0d last=%b",
                             $time, i_frame_byte, i_byte_position, i_final_byte);
                end else begin
                    want = frame_words_due.pop_front();
                    if (want.data !== i_frame_byte || want.pos !== i_byte_position ||
                        want.last !== i_final_byte) begin
                        fails++;
                        $display("%0t: mismatch exp byte=%h pos=%0d last=%b,",
                                 $time, want.data, want.pos, want.last,
                                 " got byte=%h pos=%0d last=%b",
                                 i_frame_byte, i_byte_position, i_final_byte);
                    end
                end
            end
            if (i_cfg_we) header_cfg[i_cfg_idx] = i_cfg_data;
            if (i_start && !i_busy) absorb_rx_byte(i_rx_byte);
        end
        o_fail_count = fails;
        o_pending = frame_words_due.size();
    end

endmodule

// ===== sim/tb_sysex_frame_receiver_checker_core.sv =====
`timescale 1ns / 100ps

module tb_sysex_frame_receiver_checker_core;

    localparam int BUF_DEPTH     = 64;
    localparam int ITEM_TARGET   = 380;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 80;

    typedef enum {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_HDR,
        FR_SHORT,
        FR_ABORT,
        FR_RESTART,
        FR_OVERFLOW
    } t_frame_kind;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [7:0] rx_byte;
    logic       busy;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [6:0] cfg_data;
    logic       strobe;
    logic [6:0] frame_byte;
    logic [5:0] byte_position;
    logic       final_byte;

    int         fail_count;
    int         pending_count;
    int         sent_words;
    int         quiet_cycles;
    bit         no_gaps;
    logic [6:0] hdr_now [sfrc_pkg::CFG_NUM];

    sysex_frame_receiver_checker_core #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_rx_byte      (rx_byte),
        .o_busy         (busy),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_strobe       (strobe),
        .o_frame_byte   (frame_byte),
        .o_byte_position(byte_position),
        .o_final_byte   (final_byte)
    );

    sfrc_frame_checker #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_rx_byte      (rx_byte),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_strobe       (strobe),
        .i_frame_byte   (frame_byte),
        .i_byte_position(byte_position),
        .i_final_byte   (final_byte),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || strobe) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("sysex_frame_receiver_checker_core verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input bit counted);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        rx_byte = b;
        do @(posedge clk); while (busy);
        @(negedge clk);
        if (counted) sent_words++;
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_header(input logic [6:0] m, ph, pl, v);
        cfg_we = 1'b1;
        cfg_idx = sfrc_pkg::CFG_MAKER_ID;   cfg_data = m;  @(negedge clk);
        cfg_idx = sfrc_pkg::CFG_PRODUCT_HI; cfg_data = ph; @(negedge clk);
        cfg_idx = sfrc_pkg::CFG_PRODUCT_LO; cfg_data = pl; @(negedge clk);
        cfg_idx = sfrc_pkg::CFG_VERSION;    cfg_data = v;  @(negedge clk);
        cfg_we = 1'b0;
        hdr_now[sfrc_pkg::CFG_MAKER_ID]   = m;
        hdr_now[sfrc_pkg::CFG_PRODUCT_HI] = ph;
        hdr_now[sfrc_pkg::CFG_PRODUCT_LO] = pl;
        hdr_now[sfrc_pkg::CFG_VERSION]    = v;
    endtask

    // n_body: data bytes between header and checksum
    task automatic send_frame(input t_frame_kind kind, input int n_body);
        logic [6:0] body [$];
        logic [7:0] words [$];
        logic [7:0] status;
        int sum;
        int pos;
        int keep;
        for (int i = 0; i < sfrc_pkg::CFG_NUM; i++) body.push_back(hdr_now[i]);
        for (int i = 0; i < n_body; i++) body.push_back(7'($urandom_range(0, 127)));
        if (kind == FR_BAD_HDR) begin
            pos = $urandom_range(0, sfrc_pkg::HDR_LEN - 1);
            body[pos] = body[pos] ^ (7'd1 << $urandom_range(0, 6));
        end
        if (kind == FR_SHORT) begin
            keep = $urandom_range(0, sfrc_pkg::MIN_FILL - 2);
            while (body.size() > keep) void'(body.pop_back());
        end
        sum = 0;
        foreach (body[i]) sum += body[i];
        body.push_back(7'(-sum));
        if (kind == FR_BAD_SUM)
            body[body.size() - 1] = body[body.size() - 1] + 7'($urandom_range(1, 127));
        if (kind == FR_SHORT && $urandom_range(0, 3) == 0) body.delete();

        if (kind == FR_RESTART) begin
            words.push_back(sfrc_pkg::SYX_START);
            repeat ($urandom_range(0, 5)) words.push_back({1'b0, 7'($urandom_range(0, 127))});
        end
        words.push_back(sfrc_pkg::SYX_START);
        foreach (body[i]) words.push_back({1'b0, body[i]});
        words.push_back(sfrc_pkg::SYX_END);
        if (kind == FR_ABORT) begin
            do status = 8'($urandom_range(128, 255));
            while (status == sfrc_pkg::SYX_START || status == sfrc_pkg::SYX_END);
            words.insert($urandom_range(1, words.size() - 1), status);
        end
        foreach (words[i]) send_word(words[i], 1'b1);
    endtask

    initial begin
        t_frame_kind kind;
        logic [7:0] junk;
        int phase;
        int r;
        int n;

        start = 1'b0;
        rx_byte = '0;
        cfg_we = 1'b0;
        cfg_idx = sfrc_pkg::CFG_MAKER_ID;
        cfg_data = '0;
        rst_n = 1'b0;
        no_gaps = 1'b0;
        sent_words = 0;
        hdr_now[sfrc_pkg::CFG_MAKER_ID]   = sfrc_pkg::RST_MAKER_ID;
        hdr_now[sfrc_pkg::CFG_PRODUCT_HI] = sfrc_pkg::RST_PRODUCT_HI;
        hdr_now[sfrc_pkg::CFG_PRODUCT_LO] = sfrc_pkg::RST_PRODUCT_LO;
        hdr_now[sfrc_pkg::CFG_VERSION]    = sfrc_pkg::RST_VERSION;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // end and noise outside a frame, status abort, restart, shortest good and a short frame
        send_word(sfrc_pkg::SYX_END, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(sfrc_pkg::SYX_START, 1'b1);
        send_word({1'b0, sfrc_pkg::RST_MAKER_ID}, 1'b1);
        send_word(8'h90, 1'b1);
        send_word(sfrc_pkg::SYX_START, 1'b1);
        send_word(8'h11, 1'b1);
        send_frame(FR_GOOD, 2);
        send_frame(FR_SHORT, 2);

        phase = 0;
        while (sent_words < ITEM_TARGET) begin
            drain_results();
            case (phase % 4)
                0: load_header(7'h00, 7'h00, 7'h00, 7'h00);
                1: load_header(7'h7F, 7'h7F, 7'h7F, 7'h7F);
                2: load_header(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                               7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                default: load_header(sfrc_pkg::RST_MAKER_ID, sfrc_pkg::RST_PRODUCT_HI,
                                     sfrc_pkg::RST_PRODUCT_LO, sfrc_pkg::RST_VERSION);
            endcase
            if (phase == 0) begin
                send_frame(FR_GOOD, sfrc_pkg::MAX_EMIT);
                send_frame(FR_OVERFLOW, $urandom_range(BUF_DEPTH - 4, BUF_DEPTH - 1));
            end
            repeat (6) begin
                if (sent_words >= ITEM_TARGET) break;
                no_gaps = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 5) == 0) begin
                    do junk = 8'($urandom_range(0, 255)); while (junk == sfrc_pkg::SYX_START);
                    send_word(junk, 1'b1);
                end
                r = $urandom_range(0, 99);
                if (r < 55)      kind = FR_GOOD;
                else if (r < 63) kind = FR_BAD_SUM;
                else if (r < 71) kind = FR_BAD_HDR;
                else if (r < 78) kind = FR_SHORT;
                else if (r < 87) kind = FR_ABORT;
                else if (r < 96) kind = FR_RESTART;
                else             kind = FR_OVERFLOW;
                if (kind == FR_OVERFLOW)
                    n = $urandom_range(BUF_DEPTH - 4, BUF_DEPTH - 1);
                else if ($urandom_range(0, 19) == 0)
                    n = $urandom_range(11, sfrc_pkg::MAX_EMIT);
                else
                    n = $urandom_range(2, 10);
                send_frame(kind, n);
            end
            phase++;
        end

        drain_results();
        if (fail_count == 0 && pending_count == 0) begin
            $display("sysex_frame_receiver_checker_core verification clean");
        end else begin
            $display("sysex_frame_receiver_checker_core verification failed");
        end
        $finish;
    end

endmodule
